// ----- rtl/sha512_pkg.sv -----
package sha512_pkg;

    typedef logic [63:0] t_word;

    function automatic t_word round_const(input logic [6:0] idx);
        case (idx)
            7'd0: round_const = 64'h428a2f98d728ae22; 7'd1: round_const = 64'h7137449123ef65cd;
            7'd2: round_const = 64'hb5c0fbcfec4d3b2f; 7'd3: round_const = 64'he9b5dba58189dbbc;
            7'd4: round_const = 64'h3956c25bf348b538; 7'd5: round_const = 64'h59f111f1b605d019;
            7'd6: round_const = 64'h923f82a4af194f9b; 7'd7: round_const = 64'hab1c5ed5da6d8118;
            7'd8: round_const = 64'hd807aa98a3030242; 7'd9: round_const = 64'h12835b0145706fbe;
            7'd10: round_const = 64'h243185be4ee4b28c; 7'd11: round_const = 64'h550c7dc3d5ffb4e2;
            7'd12: round_const = 64'h72be5d74f27b896f; 7'd13: round_const = 64'h80deb1fe3b1696b1;
            7'd14: round_const = 64'h9bdc06a725c71235; 7'd15: round_const = 64'hc19bf174cf692694;
            7'd16: round_const = 64'he49b69c19ef14ad2; 7'd17: round_const = 64'hefbe4786384f25e3;
            7'd18: round_const = 64'h0fc19dc68b8cd5b5; 7'd19: round_const = 64'h240ca1cc77ac9c65;
            7'd20: round_const = 64'h2de92c6f592b0275; 7'd21: round_const = 64'h4a7484aa6ea6e483;
            7'd22: round_const = 64'h5cb0a9dcbd41fbd4; 7'd23: round_const = 64'h76f988da831153b5;
            7'd24: round_const = 64'h983e5152ee66dfab; 7'd25: round_const = 64'ha831c66d2db43210;
            7'd26: round_const = 64'hb00327c898fb213f; 7'd27: round_const = 64'hbf597fc7beef0ee4;
            7'd28: round_const = 64'hc6e00bf33da88fc2; 7'd29: round_const = 64'hd5a79147930aa725;
            7'd30: round_const = 64'h06ca6351e003826f; 7'd31: round_const = 64'h142929670a0e6e70;
            7'd32: round_const = 64'h27b70a8546d22ffc; 7'd33: round_const = 64'h2e1b21385c26c926;
            7'd34: round_const = 64'h4d2c6dfc5ac42aed; 7'd35: round_const = 64'h53380d139d95b3df;
            7'd36: round_const = 64'h650a73548baf63de; 7'd37: round_const = 64'h766a0abb3c77b2a8;
            7'd38: round_const = 64'h81c2c92e47edaee6; 7'd39: round_const = 64'h92722c851482353b;
            7'd40: round_const = 64'ha2bfe8a14cf10364; 7'd41: round_const = 64'ha81a664bbc423001;
            7'd42: round_const = 64'hc24b8b70d0f89791; 7'd43: round_const = 64'hc76c51a30654be30;
            7'd44: round_const = 64'hd192e819d6ef5218; 7'd45: round_const = 64'hd69906245565a910;
            7'd46: round_const = 64'hf40e35855771202a; 7'd47: round_const = 64'h106aa07032bbd1b8;
            7'd48: round_const = 64'h19a4c116b8d2d0c8; 7'd49: round_const = 64'h1e376c085141ab53;
            7'd50: round_const = 64'h2748774cdf8eeb99; 7'd51: round_const = 64'h34b0bcb5e19b48a8;
            7'd52: round_const = 64'h391c0cb3c5c95a63; 7'd53: round_const = 64'h4ed8aa4ae3418acb;
            7'd54: round_const = 64'h5b9cca4f7763e373; 7'd55: round_const = 64'h682e6ff3d6b2b8a3;
            7'd56: round_const = 64'h748f82ee5defb2fc; 7'd57: round_const = 64'h78a5636f43172f60;
            7'd58: round_const = 64'h84c87814a1f0ab72; 7'd59: round_const = 64'h8cc702081a6439ec;
            7'd60: round_const = 64'h90befffa23631e28; 7'd61: round_const = 64'ha4506cebde82bde9;
            7'd62: round_const = 64'hbef9a3f7b2c67915; 7'd63: round_const = 64'hc67178f2e372532b;
            7'd64: round_const = 64'hca273eceea26619c; 7'd65: round_const = 64'hd186b8c721c0c207;
            7'd66: round_const = 64'heada7dd6cde0eb1e; 7'd67: round_const = 64'hf57d4f7fee6ed178;
            7'd68: round_const = 64'h06f067aa72176fba; 7'd69: round_const = 64'h0a637dc5a2c898a6;
            7'd70: round_const = 64'h113f9804bef90dae; 7'd71: round_const = 64'h1b710b35131c471b;
            7'd72: round_const = 64'h28db77f523047d84; 7'd73: round_const = 64'h32caab7b40c72493;
            7'd74: round_const = 64'h3c9ebe0a15c9bebc; 7'd75: round_const = 64'h431d67c49c100d4c;
            7'd76: round_const = 64'h4cc5d4becb3e42b6; 7'd77: round_const = 64'h597f299cfc657e2a;
            7'd78: round_const = 64'h5fcb6fab3ad6faec; 7'd79: round_const = 64'h6c44198c4a475817;
            default: round_const = '0;
        endcase
    endfunction

    function automatic t_word init_hash(input logic [2:0] idx);
        case (idx)
            3'd0: init_hash = 64'h6a09e667f3bcc908;
            3'd1: init_hash = 64'hbb67ae8584caa73b;
            3'd2: init_hash = 64'h3c6ef372fe94f82b;
            3'd3: init_hash = 64'ha54ff53a5f1d36f1;
            3'd4: init_hash = 64'h510e527fade682d1;
            3'd5: init_hash = 64'h9b05688c2b3e6c1f;
            3'd6: init_hash = 64'h1f83d9abfb41bd6b;
            3'd7: init_hash = 64'h5be0cd19137e2179;
            default: init_hash = '0;
        endcase
    endfunction

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_POS  = 7'd112;

endpackage

// ----- rtl/sha512_message_hasher_unit.sv -----
// sha-512 message hasher
// slave channel: one transfer per item, s_axis_tdata = byte_value, s_axis_tuser =
// byte_present, s_axis_tlast = end_of_message. bytes are buffered into a 128-byte ram.
// a byte that completes a block, or a transfer with tlast set, makes the block drop
// tready while one shared round unit runs the 80 rounds; the message schedule is a
// 16-word shift window loaded one byte a cycle from the ram; after the 80 rounds the
// working words are added into the chain.
// an end of message runs padding unless the length overflowed: bytes are written in
// place one per cycle, then one or two compressions follow. the eight digest words
// then leave on the master channel, word 0 first, tuser = {length_overflow,
// word_number}, tlast on word 7. a stalled receiver simply holds the current word;
// no new input is taken until word 7 has been transferred.
// reset (synchronous, active low) loads the initial hash, clears the byte count
// and returns to idle; the buffer ram is not cleared.
module sha512_message_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic [3:0]  m_axis_tuser,   // word_number, length_overflow
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_st, n_st;
    sha512_pkg::t_word r_h [8];
    sha512_pkg::t_word r_v [8];
    sha512_pkg::t_word r_w [16];
    logic [63:0] r_cnt;
    logic        r_ovf;
    logic        r_fin;       // compression belongs to the final padding
    logic        r_last;      // final block after this compression
    logic [7:0]  r_pos;       // padding write pointer / load pointer
    logic [6:0]  r_rnd;
    logic [2:0]  r_oidx;

    logic        acc;
    logic [7:0]  in_byte;
    logic        in_pres, in_eom;
    logic        ram_we;
    logic [6:0]  ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    assign in_byte = s_axis_tdata;
    assign in_pres = s_axis_tuser;
    assign in_eom  = s_axis_tlast;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    // pad byte stream generated from the byte count
    logic [6:0]  pad_fill;
    logic [7:0]  pad_byte;
    logic [127:0] bitlen;
    assign bitlen = {61'd0, r_cnt, 3'd0};
    always_comb begin
        pad_byte = '0;
        if (r_pos[6:0] >= sha512_pkg::LEN_POS && r_last) begin
            pad_byte = bitlen[8'd127 - {r_pos[3:0], 3'd0} -: 8];
        end
    end
    assign pad_fill = r_cnt[6:0];

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_cnt[6:0];
        ram_wdata = in_byte;
        if (acc && in_pres && !r_ovf && r_cnt != '1) begin
            ram_we = 1'b1;
        end else if (r_st == ST_PAD) begin
            ram_we = 1'b1;
            ram_waddr = r_pos[6:0];
            ram_wdata = (r_pos[6:0] == pad_fill && !r_fin) ? sha512_pkg::PAD_BYTE : pad_byte;
        end
    end
    assign ram_raddr = r_pos[6:0];

    sha512_ram #(.WIDTH(8), .DEPTH(128)) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared round unit
    function automatic sha512_pkg::t_word rotr(input sha512_pkg::t_word x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    sha512_pkg::t_word t1, t2, w_new, s0, s1, e, a;
    always_comb begin
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + sha512_pkg::round_const(r_rnd) + r_w[0];
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
        s0 = rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        s1 = rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        w_new = s1 + r_w[9] + s0 + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_fin <= 1'b0;
            r_last <= 1'b0;
            r_pos <= '0;
            r_rnd <= '0;
            r_oidx <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::init_hash(3'(i));
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (acc) begin
                        logic ovf_now;
                        logic [63:0] cnt_now;
                        ovf_now = r_ovf;
                        cnt_now = r_cnt;
                        if (in_pres && !r_ovf) begin
                            if (r_cnt == '1) begin
                                ovf_now = 1'b1;
                                for (int i = 0; i < 8; i++) r_h[i] <= '0;
                            end else begin
                                cnt_now = r_cnt + 64'd1;
                            end
                        end
                        r_ovf <= ovf_now;
                        r_cnt <= cnt_now;
                        r_fin <= 1'b0;
                        if (in_pres && !r_ovf && r_cnt != '1 && r_cnt[6:0] == 7'd127) begin
                            r_st <= ST_LOAD;
                            r_pos <= '0;
                            r_last <= 1'b0;
                            r_fin <= in_eom;
                        end else if (in_eom) begin
                            if (ovf_now) begin
                                r_st <= ST_OUT;
                                r_oidx <= '0;
                            end else begin
                                r_st <= ST_PAD;
                                r_pos <= {1'b0, cnt_now[6:0]};
                                r_last <= !(cnt_now[6:0] >= 7'd112);
                            end
                        end
                    end
                end
                ST_PAD: begin
                    r_fin <= 1'b1;
                    if (r_pos[6:0] == 7'd127) begin
                        r_st <= ST_LOAD;
                        r_pos <= '0;
                    end else begin
                        r_pos <= r_pos + 8'd1;
                    end
                end
                ST_LOAD: begin
                    // ram read data is registered and follows its address in the next cycle
                    r_pos <= r_pos + 8'd1;
                    if (r_pos != 8'd0) begin
                        r_w[15] <= {r_w[15][55:0], ram_rdata};
                        if (r_pos[2:0] == 3'd1) begin
                            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        end
                    end
                    if (r_pos == 8'd128) begin
                        r_st <= ST_RND;
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                ST_RND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) r_st <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (!r_fin) begin
                        r_st <= ST_IDLE;
                    end else if (r_last) begin
                        r_st <= ST_OUT;
                        r_oidx <= '0;
                    end else begin
                        r_st <= ST_PAD;
                        r_pos <= '0;
                        r_last <= 1'b1;
                        r_fin <= (r_cnt[6:0] != 7'd0);
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_st <= ST_IDLE;
                            r_cnt <= '0;
                            r_ovf <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::init_hash(3'(i));
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata  = r_h[r_oidx];
    assign m_axis_tuser  = {r_ovf, r_oidx};
    assign m_axis_tlast  = (r_oidx == 3'd7);

endmodule

// ----- rtl/sha512_ram.sv -----
module sha512_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/sha512_checker.sv -----
module sha512_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during digest");

    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1)
        else $error("digest word order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tlast == (m_axis_tuser[2:0] == 3'd7))
        else $error("last flag");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tdata == 64'd0)
        else $error("overflow digest not zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled word changed");

endmodule

bind sha512_message_hasher_unit sha512_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
